// ----- hw/rtl/lcgr_pkg.sv -----
// Package for the combined LCG generator with table shuffle.
// Holds the moduli, multipliers, table geometry, state codes and step-unit structs.
// It has no dependencies.
`default_nettype none
package lcgr_pkg;

   localparam int VAL_W = 31;

   localparam logic [30:0] MOD_ONE  = 31'd2147483563;
   localparam logic [30:0] MOD_TWO  = 31'd2147483399;
   localparam logic [30:0] WRAP_ADD = 31'd2147483562;
   localparam logic [15:0] MUL_ONE  = 16'd40014;
   localparam logic [15:0] MUL_TWO  = 16'd40692;
   // These are 2^31 modulo each modulus and fold the high product bits back in.
   localparam logic [7:0]  FOLD_ONE = 8'd85;
   localparam logic [7:0]  FOLD_TWO = 8'd249;

   localparam int PROD_W = VAL_W + 16;

   localparam int TABLE_SIZE = 32;
   localparam int TABLE_AW   = $clog2(TABLE_SIZE);
   localparam int SLOT_SHIFT = 26;
   localparam logic [26:0] SLOT_DIV = 27'd67108862;

   localparam int WARM_STEPS = 8;
   localparam int SEED_STEPS = WARM_STEPS + TABLE_SIZE;
   localparam int CNT_W      = $clog2(SEED_STEPS);

   localparam int CSR_AW = 3;
   localparam logic REG_SEED = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SEED = 4'b0010,
      ST_DRAW = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic             go;
      logic [VAL_W-1:0] first;
      logic [VAL_W-1:0] second;
   } step_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] first;
      logic [VAL_W-1:0] second;
   } step_rsp_type;

endpackage
`default_nettype wire

// ----- hw/rtl/combined_lcg_shuffle_rng.sv -----
// Combined LCG generator with a 32-entry shuffle table held in a RAM.
// A plain draw runs one step of the shared step unit and a table read, registers the
// result and then the response; no new request is taken until the response is registered.
// A seeding draw adds 40 steps through the same unit.
// Reset clears all control state; the table holds no valid data until seeded.
// It depends on lcgr_pkg, lcgr_ram and lcgr_step.
`default_nettype none
module combined_lcg_shuffle_rng (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_reseed,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [lcgr_pkg::VAL_W-1:0]   rsp_value,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [lcgr_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic      [31:0]                  csr_prdata,
   output logic                              csr_pready
);
   import lcgr_pkg::*;

   state_type          state_ff, state_in;
   logic [VAL_W-1:0]   seed_ff, seed_in;
   logic [VAL_W-1:0]   s1_ff, s1_in, s2_ff, s2_in;
   logic [VAL_W-1:0]   last_ff, last_in;
   logic [VAL_W-1:0]   y_ff, y_in;
   logic               seeded_ff, seeded_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               go_ff, go_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;

   logic               csr_write;
   logic [VAL_W-1:0]   seed_clamped;
   logic [TABLE_AW-1:0] q0, slot;
   logic [26:0]        rem;
   logic signed [32:0] diff, wrapped;
   logic [VAL_W-1:0]   y_calc;
   logic [CNT_W-1:0]   fill_index;

   logic                ram_we;
   logic [TABLE_AW-1:0] ram_waddr;
   logic [VAL_W-1:0]    ram_wdata;
   logic [VAL_W-1:0]    ram_rdata;

   step_req_type step_req;
   step_rsp_type step_rsp;

   lcgr_ram #(
      .WIDTH(VAL_W),
      .DEPTH(TABLE_SIZE)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (go_ff),
      .raddr (slot),
      .rdata (ram_rdata)
   );

   lcgr_step u_step (
      .clock (clock),
      .reset (reset),
      .req   (step_req),
      .rsp   (step_rsp)
   );

   assign step_req.go     = go_ff;
   assign step_req.first  = s1_ff;
   assign step_req.second = s2_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_SEED) ? {1'b0, seed_ff} : 32'd0;

   always_comb begin
      seed_clamped = seed_ff;
      if (seed_ff == '0) begin
         seed_clamped = VAL_W'(1);
      end else if (seed_ff > WRAP_ADD) begin
         seed_clamped = WRAP_ADD;
      end
   end

   // The slot is the last output divided by the slot width, with one correction step.
   always_comb begin
      q0   = last_ff[VAL_W-1:SLOT_SHIFT];
      rem  = {1'b0, last_ff[SLOT_SHIFT-1:0]} + {21'd0, q0, 1'b0};
      slot = (rem >= SLOT_DIV) ? q0 + TABLE_AW'(1) : q0;
   end

   always_comb begin
      diff    = $signed({2'b00, ram_rdata}) - $signed({2'b00, step_rsp.second});
      wrapped = diff;
      if (diff < 33'sd1) begin
         wrapped = diff + $signed({2'b00, WRAP_ADD});
      end
      if (wrapped < 33'sd1) begin
         y_calc = VAL_W'(1);
      end else if (wrapped > $signed({2'b00, WRAP_ADD})) begin
         y_calc = WRAP_ADD;
      end else begin
         y_calc = wrapped[VAL_W-1:0];
      end
   end

   assign fill_index = CNT_W'(SEED_STEPS - 1) - cnt_ff;
   assign req_ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      last_in      = last_ff;
      y_in         = y_ff;
      seeded_in    = seeded_ff;
      cnt_in       = cnt_ff;
      go_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_value_in = rsp_value_ff;
      ram_we       = 1'b0;
      ram_waddr    = slot;
      ram_wdata    = step_rsp.first;

      if (csr_write && csr_paddr[2] == REG_SEED) begin
         seed_in = csr_pwdata[VAL_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               go_in = 1'b1;
               if (req_reseed || !seeded_ff) begin
                  s1_in    = seed_clamped;
                  s2_in    = seed_clamped;
                  cnt_in   = '0;
                  state_in = ST_SEED;
               end else begin
                  state_in = ST_DRAW;
               end
            end
         end
         ST_SEED: begin
            if (step_rsp.done) begin
               s1_in = step_rsp.first;
               if (cnt_ff >= CNT_W'(WARM_STEPS)) begin
                  ram_we    = 1'b1;
                  ram_waddr = fill_index[TABLE_AW-1:0];
               end
               go_in = 1'b1;
               if (cnt_ff == CNT_W'(SEED_STEPS - 1)) begin
                  last_in   = step_rsp.first;
                  seeded_in = 1'b1;
                  state_in  = ST_DRAW;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_DRAW: begin
            if (step_rsp.done) begin
               s1_in    = step_rsp.first;
               s2_in    = step_rsp.second;
               ram_we   = 1'b1;
               y_in     = y_calc;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = y_ff;
               last_in      = y_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= VAL_W'(1);
         s1_ff        <= '0;
         s2_ff        <= '0;
         last_ff      <= '0;
         seeded_ff    <= 1'b0;
         cnt_ff       <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         last_ff      <= last_in;
         seeded_ff    <= seeded_in;
         cnt_ff       <= cnt_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      y_ff         <= y_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/lcgr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// It has no dependencies.
`default_nettype none
module lcgr_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/lcgr_step.sv -----
// Two-stage Lehmer step unit that advances both sequences at once.
// It depends on lcgr_pkg for the moduli, multipliers and step structs.
`default_nettype none
module lcgr_step (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lcgr_pkg::step_req_type req,
   output lcgr_pkg::step_rsp_type     rsp
);
   import lcgr_pkg::*;

   logic [PROD_W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic              v1_ff, v1_in;
   logic [VAL_W-1:0]  s1_ff, s1_in, s2_ff, s2_in;
   logic              done_ff, done_in;
   logic [31:0]       f1, f2;

   assign p1_in = {16'd0, req.first} * {31'd0, MUL_ONE};
   assign p2_in = {16'd0, req.second} * {31'd0, MUL_TWO};
   assign v1_in = req.go;

   assign f1 = {1'b0, p1_ff[VAL_W-1:0]}
             + {8'd0, {8'd0, p1_ff[PROD_W-1:VAL_W]} * {16'd0, FOLD_ONE}};
   assign f2 = {1'b0, p2_ff[VAL_W-1:0]}
             + {8'd0, {8'd0, p2_ff[PROD_W-1:VAL_W]} * {16'd0, FOLD_TWO}};

   always_comb begin
      s1_in = (f1 >= {1'b0, MOD_ONE}) ? VAL_W'(f1 - {1'b0, MOD_ONE}) : f1[VAL_W-1:0];
      s2_in = (f2 >= {1'b0, MOD_TWO}) ? VAL_W'(f2 - {1'b0, MOD_TWO}) : f2[VAL_W-1:0];
      done_in = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         done_ff <= done_in;
      end
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.first  = s1_ff;
   assign rsp.second = s2_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/lcgr_checker.sv -----
// Port-level checker for the combined LCG generator, bound to the top level.
// It depends on lcgr_pkg and combined_lcg_shuffle_rng.
`default_nettype none
module lcgr_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [lcgr_pkg::VAL_W-1:0]   rsp_value,
   input wire logic                         csr_psel,
   input wire logic                         csr_penable,
   input wire logic                         csr_pwrite,
   input wire logic [lcgr_pkg::CSR_AW-1:0]  csr_paddr,
   input wire logic [31:0]                  csr_pwdata,
   input wire logic [31:0]                  csr_prdata,
   input wire logic                         csr_pready
);
   import lcgr_pkg::*;

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("Generator not ready for a request after reset.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Generator accepted a request while another was in flight.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("Stalled result changed or dropped.");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_value != '0 && rsp_value <= WRAP_ADD)
      else $error("Result outside the output range.");

   a_seed_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[2] == REG_SEED
      |=> csr_paddr[2] != REG_SEED || csr_prdata == {1'b0, $past(csr_pwdata[VAL_W-1:0])})
      else $error("Seed register does not read back the written value.");

endmodule

bind combined_lcg_shuffle_rng lcgr_checker u_lcgr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_value   (rsp_value),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);
`default_nettype wire

// ----- verif/combined_lcg_shuffle_rng_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for combined_lcg_shuffle_rng: it predicts every draw of the
// combined generator with its shuffle table and compares each returned value in order.
// It depends only on the RTL and on lcgr_pkg for the port widths and register index.
module combined_lcg_shuffle_rng_tb;

   localparam logic [30:0] MODULUS_A  = 31'd2147483563;
   localparam logic [30:0] MODULUS_B  = 31'd2147483399;
   localparam logic [30:0] VALUE_MAX  = 31'd2147483562;
   localparam logic [15:0] MULT_A     = 16'd40014;
   localparam logic [15:0] MULT_B     = 16'd40692;
   localparam logic [31:0] SLOT_WIDTH = 32'd67108862;
   localparam int SHUFFLE_DEPTH = 32;
   localparam int WARMUP_STEPS  = 8;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_REPORTS   = 40;

   typedef logic [lcgr_pkg::CSR_AW-1:0] csr_addr_type;
   localparam csr_addr_type SEED_ADDR     = csr_addr_type'(4 * lcgr_pkg::REG_SEED);
   localparam csr_addr_type UNMAPPED_ADDR = csr_addr_type'(4 * (lcgr_pkg::REG_SEED + 1));

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_reseed;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [lcgr_pkg::VAL_W-1:0] rsp_value;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   csr_addr_type csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   logic [30:0] gen_seed = 31'd1;
   logic [30:0] seq_a = '0;
   logic [30:0] seq_b = '0;
   logic [30:0] prev_value = '0;
   logic [30:0] shuffle [SHUFFLE_DEPTH];
   logic gen_seeded = 1'b0;

   logic [30:0] expected_values [$];
   int mismatch_count = 0;
   int burst_left = 0;
   int hold_left = 0;
   int pattern_left = 0;
   int stall_pct = 0;
   int idle_cycles = 0;

   combined_lcg_shuffle_rng dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_reseed(req_reseed),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_value(rsp_value),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   function automatic logic [30:0] lehmer(input logic [30:0] z, input logic [15:0] mult,
                                          input logic [30:0] modulus);
      logic [63:0] product;
      product = {33'd0, z} * {48'd0, mult};
      return 31'(product % {33'd0, modulus});
   endfunction

   function void seed_generator();
      logic [30:0] start;
      start = gen_seed;
      if (start < 31'd1) start = 31'd1;
      if (start > VALUE_MAX) start = VALUE_MAX;
      seq_a = start;
      seq_b = start;
      for (int j = SHUFFLE_DEPTH + WARMUP_STEPS - 1; j >= 0; j--) begin
         seq_a = lehmer(seq_a, MULT_A, MODULUS_A);
         if (j < SHUFFLE_DEPTH) shuffle[j] = seq_a;
      end
      prev_value = shuffle[0];
      gen_seeded = 1'b1;
   endfunction

   function logic [30:0] predict_draw(input logic reseed);
      logic [4:0] slot;
      longint diff;
      if (!gen_seeded || reseed) seed_generator();
      seq_a = lehmer(seq_a, MULT_A, MODULUS_A);
      seq_b = lehmer(seq_b, MULT_B, MODULUS_B);
      slot = 5'({1'b0, prev_value} / SLOT_WIDTH);
      diff = longint'(shuffle[slot]) - longint'(seq_b);
      shuffle[slot] = seq_a;
      if (diff < 1) diff = diff + longint'(VALUE_MAX);
      if (diff < 1) diff = 1;
      if (diff > longint'(VALUE_MAX)) diff = longint'(VALUE_MAX);
      prev_value = 31'(diff);
      return prev_value;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) expected_values.push_back(predict_draw(req_reseed));
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               report_mismatch("unrequested value", 32'd0, {1'b0, rsp_value});
            end else begin
               if (rsp_value !== expected_values[0])
                  report_mismatch("value", {1'b0, expected_values[0]}, {1'b0, rsp_value});
               void'(expected_values.pop_front());
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
            pattern_left = $urandom_range(20, 80);
         end
         pattern_left = pattern_left - 1;
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_draw(input logic reseed);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid = 1'b1;
      req_reseed = reseed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_draws(input int count, input int reseed_pct);
      for (int i = 0; i < count; i++) send_draw($urandom_range(0, 99) < reseed_pct);
      req_valid = 1'b0;
      burst_left = 0;
   endtask

   task automatic wait_idle();
      while (expected_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input csr_addr_type addr, input logic [31:0] data);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (addr == SEED_ADDR) gen_seed = data[30:0];
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic check_seed_readback();
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = SEED_ADDR;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata !== {1'b0, gen_seed})
         report_mismatch("seed readback", {1'b0, gen_seed}, csr_prdata);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic write_seed(input logic [31:0] data);
      csr_write(SEED_ADDR, data);
      check_seed_readback();
   endtask

   function automatic logic [31:0] edge_seed(input int k);
      case (k)
         0: return 32'd0;
         1: return 32'd1;
         2: return {1'b0, VALUE_MAX};
         3: return {1'b0, MODULUS_A};
         4: return 32'h7FFF_FFFF;
         5: return 32'hFFFF_FFFF;
         6: return {1'b0, MODULUS_B};
         default: return 32'h2AAA_AAAA;
      endcase
   endfunction

   // The first draw seeds itself from the reset value of the seed register.
   task automatic test_first_draw_after_reset();
      check_seed_readback();
      for (int i = 0; i < 5; i++) send_draw(1'b0);
      send_draw(1'b1);
      req_valid = 1'b0;
      burst_left = 0;
      wait_idle();
   endtask

   task automatic test_seed_extremes();
      for (int k = 0; k < 8; k++) begin
         write_seed(edge_seed(k));
         send_draw(1'b1);
         send_draw(1'b0);
         req_valid = 1'b0;
         burst_left = 0;
         wait_idle();
      end
   endtask

   task automatic test_unmapped_register();
      write_seed(32'd12345);
      csr_write(UNMAPPED_ADDR, $urandom);
      check_seed_readback();
      send_draw(1'b1);
      send_draw(1'b0);
      req_valid = 1'b0;
      burst_left = 0;
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      write_seed($urandom_range(1, 32'd2147483562));
      hold_left = HOLD_CYCLES;
      run_draws(40, 5);
      wait_idle();
   endtask

   task automatic test_random_draws();
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) write_seed($urandom);
         else write_seed($urandom_range(1, 32'd2147483562));
         run_draws(95, 6);
         wait_idle();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_reseed = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_first_draw_after_reset();
      test_seed_extremes();
      test_unmapped_register();
      test_output_backpressure();
      test_random_draws();

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
